### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the deque checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Types and constants shared by the circular deque and its checker.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int DATA_W    = 32;
    localparam int FUNC_W    = 3;
    localparam int STATUS_W  = 2;

    // Operation codes; unused codes behave as a query.
    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_QUERY      = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    // Word shown at both ends when nothing is held.
    localparam logic signed [DATA_W-1:0] EMPTY_WORD = '1;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] data;
    } t_cdq_in;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] rear_value;
        logic                     is_empty;
        logic                     is_full;
    } t_cdq_out;

endpackage

### design/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of 32-bit words held in a circular memory of DEPTH slots.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake               Payload
//   -------   ---------   ---------------------   ---------
//   in        input       i_in_valid / o_in_stall   t_cdq_in
//   out       output      o_out_valid / i_out_stall t_cdq_out
//
// A beat moves the pointers and writes any pushed word at its accepting edge.
// The pending result then reads the front and rear words into the output
// register once the output is free or its last result is taken.
// Beats follow at one per cycle while the output is not stalled. The input
// stalls only while a stalled result holds the output and the next one waits.
// Reset empties the deque at once; the memory contents are not cleared.
// ----------------------------------------------------------------------------
module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_cdq_in  i_in,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_cdq_out o_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
        return (i == '0) ? LAST_IDX : i - 1'b1;
    endfunction

    // Word store.
    logic signed [DATA_W-1:0] mem [DEPTH];

    // Pointer state.
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic          r_empty, n_empty;

    // Result waiting for its memory read.
    logic                r_pend;
    logic [STATUS_W-1:0] r_p_status, n_status;

    // Output register.
    logic                     r_out_valid;
    logic [STATUS_W-1:0]      r_o_status;
    logic signed [DATA_W-1:0] r_o_front;
    logic signed [DATA_W-1:0] r_o_rear;
    logic                     r_o_empty;
    logic                     r_o_full;

    logic          accept;
    logic          load;
    logic          full_now;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    // The pending result moves to the output when the output is free or taken.
    assign load       = r_pend && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_pend && !load;
    assign accept     = i_in_valid && !o_in_stall;
    assign full_now   = !r_empty && (idx_next(r_tail) == r_head);

    // Pointer update and write request for the incoming operation.
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_empty  = r_empty;
        n_status = ST_OK;
        wr_en    = 1'b0;
        wr_addr  = r_tail;
        unique case (i_in.func)
            FUNC_PUSH_BACK, FUNC_PUSH_FRONT: begin
                if (full_now) begin
                    n_status = ST_OVERFLOW;
                end else if (r_empty) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b0;
                    wr_en   = 1'b1;
                    wr_addr = '0;
                end else if (i_in.func == FUNC_PUSH_BACK) begin
                    n_tail  = idx_next(r_tail);
                    wr_en   = 1'b1;
                    wr_addr = idx_next(r_tail);
                end else begin
                    n_head  = idx_prev(r_head);
                    wr_en   = 1'b1;
                    wr_addr = idx_prev(r_head);
                end
            end
            FUNC_POP_FRONT, FUNC_POP_BACK: begin
                if (r_empty) begin
                    n_status = ST_UNDERFLOW;
                end else if (r_head == r_tail) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b1;
                end else if (i_in.func == FUNC_POP_FRONT) begin
                    n_head = idx_next(r_head);
                end else begin
                    n_tail = idx_prev(r_tail);
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_empty     <= 1'b1;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_empty <= n_empty;
            end
            r_pend <= accept || (r_pend && !load);
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Status of the beat in flight.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_status <= n_status;
        end
    end

    // Memory write port. A push writes a free slot, so it never disturbs the
    // words that a pending result reads at the same edge.
    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            mem[wr_addr] <= i_in.data;
        end
    end

    // Memory read ports, registered into the output stage.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_front  <= mem[r_head];
            r_o_rear   <= mem[r_tail];
            r_o_status <= r_p_status;
            r_o_empty  <= r_empty;
            r_o_full   <= full_now;
        end
    end

    // Result beat.
    assign o_out_valid       = r_out_valid;
    assign o_out.status      = r_o_status;
    assign o_out.front_value = r_o_empty ? EMPTY_WORD : r_o_front;
    assign o_out.rear_value  = r_o_empty ? EMPTY_WORD : r_o_rear;
    assign o_out.is_empty    = r_o_empty;
    assign o_out.is_full     = r_o_full;

endmodule

### design/cdq_checker.sv
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks on the circular deque, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdq_checker
    import cdq_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_cdq_out o_out
);

    // Reset drops any result on the output.
    `ASSERT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "result after reset")

    // A stalled result holds until taken.
    `ASSERT_RST(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out), "stalled result changed")

    // The input stalls only while the output holds a stalled result.
    `ASSERT_RST(a_stall_cause, i_clk, i_rst_n,
        o_in_stall |-> o_out_valid && i_out_stall, "input stall without output back-pressure")

    // The input stalls only while an accepted beat is still in flight.
    `ASSERT_RST(a_stall_origin, i_clk, i_rst_n,
        o_in_stall |-> $past(i_in_valid && !o_in_stall) || $past(o_in_stall),
        "input stall without a beat in flight")

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);
